### rtl/core/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg
// shared types and constants of the software timer table
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int TIMER_SLOTS_DEF = 16;

  localparam int KIND_W   = 3;
  localparam int SEC_W    = 31;
  localparam int DSEC_W   = 32;
  localparam int USEC_W   = 20;
  localparam int HANDLE_W = 4;
  localparam int REP_W    = 16;
  localparam int UD_W     = 32;
  localparam int STAT_W   = 2;
  localparam int FC_W     = 2;

  localparam logic [USEC_W:0] USEC_PER_SEC = 21'd1000000;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE,
    KIND_RESET,
    KIND_RESTART,
    KIND_CANCEL,
    KIND_CHECK,
    KIND_QUERY,
    KIND_SET,
    KIND_NONE
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_ZERO_PERIOD,
    ST_FULL,
    ST_NOT_ACTIVE
  } status_e;

  typedef enum logic [1:0] {
    TU_ADD,
    TU_NORM,
    TU_CMP
  } tu_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE,
    S_RD,
    S_CAP,
    S_UNLINK,
    S_LOADIN,
    S_ARM_ADD,
    S_ARM_NORM,
    S_LINK,
    S_LCNT,
    S_LSHIFT,
    S_WRITE,
    S_CHK,
    S_OFIND,
    S_SUMMARY,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [DSEC_W-1:0]       dsec;
    logic [USEC_W-1:0]       dusec;
    logic [SEC_W-1:0]        psec;
    logic [USEC_W-1:0]       pusec;
    logic signed [REP_W-1:0] rep;
    logic signed [UD_W-1:0]  ud;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic [DSEC_W:0] sec;
    logic [USEC_W:0] us;
    logic            step;
    logic            lt;
    logic            eq;
  } tu_res_t;

endpackage

### rtl/core/tst_if.sv
// ----------------------------------------------------------------------------
// tst_req_if / tst_rsp_if
// valid-ready channels carrying timer requests and results
// ----------------------------------------------------------------------------
interface tst_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [30:0]        now_sec;
  logic [19:0]        now_usec;
  logic [3:0]         handle;
  logic [30:0]        period_sec;
  logic [19:0]        period_usec;
  logic signed [15:0] repeat_count;
  logic signed [31:0] user_data;

  modport source (output valid, kind, now_sec, now_usec, handle, period_sec, period_usec,
                  repeat_count, user_data, input ready);
  modport sink (input valid, kind, now_sec, now_usec, handle, period_sec, period_usec,
                repeat_count, user_data, output ready);
endinterface

interface tst_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [3:0]         handle_out;
  logic               fired;
  logic [30:0]        out_period_sec;
  logic [19:0]        out_period_usec;
  logic signed [15:0] out_repeat;
  logic signed [31:0] out_user_data;
  logic [1:0]         fired_count;
  logic               last;

  modport source (output valid, status, handle_out, fired, out_period_sec, out_period_usec,
                  out_repeat, out_user_data, fired_count, last, input ready);
  modport sink (input valid, status, handle_out, fired, out_period_sec, out_period_usec,
                out_repeat, out_user_data, fired_count, last, output ready);
endinterface

### rtl/core/software_timer_table.sv
// ----------------------------------------------------------------------------
// software_timer_table
// one-shot and periodic timer table with ordered lists, run by a sequencer
//
//   channel | dir | transaction
//   req_i   | in  | create, reset, restart, cancel, check, query, set
//   rsp_o   | out | status and slot contents, one to three per request
//
// each slot scan reads the slot ram one entry a cycle, and normalizing the
// microseconds takes up to two steps of the shared time unit.
// reset clears the slot occupancy and the sequencer; the table needs no sweep.
// req_i is ready only in idle; a stalled rsp_o holds the sequencer in place.
// ----------------------------------------------------------------------------
module software_timer_table #(
  parameter int TIMER_SLOTS = tst_pkg::TIMER_SLOTS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  tst_req_if.sink    req_i,
  tst_rsp_if.source  rsp_o
);
  import tst_pkg::*;

  localparam int SW = $clog2(TIMER_SLOTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(TIMER_SLOTS - 1);

  state_e state_q, state_d, ret_q, ret_d;

  kind_e                   kind_q, kind_d;
  logic [SEC_W-1:0]        now_sec_q, now_sec_d;
  logic [USEC_W-1:0]       now_usec_q, now_usec_d;
  logic [HANDLE_W-1:0]     h_q, h_d;
  logic [SEC_W-1:0]        psec_q, psec_d;
  logic [USEC_W-1:0]       pusec_q, pusec_d;
  logic signed [REP_W-1:0] rep_in_q, rep_in_d;
  logic signed [UD_W-1:0]  ud_in_q, ud_in_d;

  logic [SW-1:0] tgt_q, tgt_d, idx_q, idx_d, rd_idx_q, rd_idx_d;
  logic [SW-1:0] best_q, best_d, best_pos_q, best_pos_d, pcnt_q, pcnt_d;
  logic          rd_vld_q, rd_vld_d, issue_q, issue_d, found_q, found_d;
  logic          phase_q, phase_d;
  logic [FC_W-1:0] fired_q, fired_d;

  rec_t            rec_q, rec_d;
  logic [DSEC_W:0] arm_sec_q, arm_sec_d;
  logic [USEC_W:0] arm_us_q, arm_us_d;

  logic [TIMER_SLOTS-1:0] in_use_q, in_use_d, in_rep_q, in_rep_d;
  logic [SW-1:0]          pos_q [TIMER_SLOTS];
  logic [SW-1:0]          pos_d [TIMER_SLOTS];

  status_e             pend_st_q, pend_st_d;
  logic [HANDLE_W-1:0] pend_h_q, pend_h_d;
  logic                pend_fired_q, pend_fired_d, pend_data_q, pend_data_d;
  logic                pend_sum_q, pend_sum_d;

  logic                    rsp_valid_q, rsp_valid_d;
  status_e                 rsp_st_q, rsp_st_d;
  logic [HANDLE_W-1:0]     rsp_h_q, rsp_h_d;
  logic                    rsp_fired_q, rsp_fired_d, rsp_last_q, rsp_last_d;
  logic [SEC_W-1:0]        rsp_psec_q, rsp_psec_d;
  logic [USEC_W-1:0]       rsp_pusec_q, rsp_pusec_d;
  logic signed [REP_W-1:0] rsp_rep_q, rsp_rep_d;
  logic signed [UD_W-1:0]  rsp_ud_q, rsp_ud_d;
  logic [FC_W-1:0]         rsp_fc_q, rsp_fc_d;

  logic            ram_we;
  logic [SW-1:0]   ram_raddr;
  rec_t            ram_rdata;
  logic [REC_W-1:0] ram_rdata_raw;

  tu_op_e          tu_op;
  logic [DSEC_W:0] tu_a_sec, tu_b_sec;
  logic [USEC_W:0] tu_a_us, tu_b_us;
  tu_res_t         tu_res;

  logic                accept, req_active, req_zero, zero_per;
  kind_e               req_kind;
  logic [SW+HANDLE_W-1:0] req_hext, tgt_ext;
  logic [SW-1:0]       req_hidx;
  logic [HANDLE_W-1:0] tgt_h;
  logic                last_idx, rd_last, expired, chk_hit, cnt_hit, ofind_hit, emit_go;

  tst_ram #(
    .WIDTH (REC_W),
    .DEPTH (TIMER_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tgt_q),
    .wdata_i (rec_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = rec_t'(ram_rdata_raw);

  tst_time_unit u_time (
    .op_i    (tu_op),
    .a_sec_i (tu_a_sec),
    .a_us_i  (tu_a_us),
    .b_sec_i (tu_b_sec),
    .b_us_i  (tu_b_us),
    .res_o   (tu_res)
  );

  // request decode
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && (state_q == S_IDLE);
  assign req_kind    = kind_e'(req_i.kind);
  assign req_hext    = {{SW{1'b0}}, req_i.handle};
  assign req_hidx    = req_hext[SW-1:0];
  assign req_active  = (32'(req_i.handle) < TIMER_SLOTS) && in_use_q[req_hidx];
  assign req_zero    = (req_i.period_sec == '0) && (req_i.period_usec == '0);
  assign zero_per    = (psec_q == '0) && (pusec_q == '0);
  assign tgt_ext     = {{HANDLE_W{1'b0}}, tgt_q};
  assign tgt_h       = tgt_ext[HANDLE_W-1:0];

  assign last_idx  = (idx_q == LAST_IDX);
  assign rd_last   = rd_vld_q && (rd_idx_q == LAST_IDX);
  assign expired   = tu_res.lt || tu_res.eq;
  assign chk_hit   = rd_vld_q && in_use_q[rd_idx_q] && in_rep_q[rd_idx_q] && expired &&
                     (!found_q || (pos_q[rd_idx_q] < best_pos_q));
  assign cnt_hit   = rd_vld_q && (rd_idx_q != tgt_q) && in_use_q[rd_idx_q] &&
                     (in_rep_q[rd_idx_q] == in_rep_q[tgt_q]) && (in_rep_q[tgt_q] || tu_res.lt);
  assign ofind_hit = in_use_q[idx_q] && !in_rep_q[idx_q] && (pos_q[idx_q] == '0);
  assign emit_go   = !rsp_valid_q || rsp_o.ready;

  // time unit operands
  always_comb begin
    tu_op    = TU_CMP;
    tu_a_sec = '0;
    tu_a_us  = '0;
    tu_b_sec = {2'b00, now_sec_q};
    tu_b_us  = {1'b0, now_usec_q};
    ram_raddr = idx_q;
    unique case (state_q)
      S_ARM_ADD: begin
        tu_op    = TU_ADD;
        tu_a_sec = {2'b00, now_sec_q};
        tu_a_us  = {1'b0, now_usec_q};
        tu_b_sec = {2'b00, rec_q.psec};
        tu_b_us  = {1'b0, rec_q.pusec};
      end
      S_ARM_NORM: begin
        tu_op    = TU_NORM;
        tu_a_sec = arm_sec_q;
        tu_a_us  = arm_us_q;
      end
      S_CAP, S_CHK: begin
        tu_a_sec = {1'b0, ram_rdata.dsec};
        tu_a_us  = {1'b0, ram_rdata.dusec};
      end
      S_LCNT: begin
        tu_a_sec = {1'b0, ram_rdata.dsec};
        tu_a_us  = {1'b0, ram_rdata.dusec};
        tu_b_sec = {1'b0, rec_q.dsec};
        tu_b_us  = {1'b0, rec_q.dusec};
      end
      default: begin
      end
    endcase
    if (state_q == S_RD) begin
      ram_raddr = tgt_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (req_kind == KIND_NONE) begin
            state_d = S_EMIT;
          end else if ((req_kind == KIND_RESTART || req_kind == KIND_CANCEL ||
                        req_kind == KIND_QUERY || req_kind == KIND_SET) && !req_active) begin
            state_d = S_EMIT;
          end else if (req_kind == KIND_RESET && req_active) begin
            state_d = S_UNLINK;
          end else if (req_kind == KIND_CREATE || req_kind == KIND_RESET) begin
            state_d = req_zero ? S_EMIT : S_FREE;
          end else if (req_kind == KIND_CHECK) begin
            state_d = S_CHK;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_FREE: begin
        if (!in_use_q[idx_q]) begin
          state_d = S_LOADIN;
        end else if (last_idx) begin
          state_d = S_EMIT;
        end
      end
      S_RD: state_d = S_CAP;
      S_CAP: begin
        unique case (kind_q)
          KIND_CHECK: begin
            if (phase_q) begin
              state_d = expired ? S_EMIT : S_SUMMARY;
            end else begin
              state_d = S_ARM_ADD;
            end
          end
          KIND_QUERY: state_d = S_EMIT;
          KIND_SET:   state_d = S_WRITE;
          default:    state_d = S_UNLINK;
        endcase
      end
      S_UNLINK: begin
        unique case (kind_q)
          KIND_RESET:   state_d = zero_per ? S_EMIT : S_LOADIN;
          KIND_RESTART: state_d = S_ARM_ADD;
          KIND_CHECK: begin
            if (phase_q) begin
              state_d = S_SUMMARY;
            end else begin
              state_d = (rec_q.rep == '0) ? S_WRITE : S_LINK;
            end
          end
          default: state_d = S_EMIT;
        endcase
      end
      S_LOADIN:  state_d = S_ARM_ADD;
      S_ARM_ADD: state_d = S_ARM_NORM;
      S_ARM_NORM: begin
        if (!tu_res.step) begin
          state_d = (kind_q == KIND_CHECK) ? S_EMIT : S_LINK;
        end
      end
      S_LINK: state_d = S_LCNT;
      S_LCNT: begin
        if (rd_last) begin
          state_d = S_LSHIFT;
        end
      end
      S_LSHIFT: state_d = S_WRITE;
      S_WRITE:  state_d = (kind_q == KIND_CHECK) ? S_OFIND : S_EMIT;
      S_CHK: begin
        if (rd_last) begin
          state_d = (found_q || chk_hit) ? S_RD : S_OFIND;
        end
      end
      S_OFIND: begin
        if (ofind_hit) begin
          state_d = S_RD;
        end else if (last_idx) begin
          state_d = S_SUMMARY;
        end
      end
      S_SUMMARY: state_d = S_EMIT;
      S_EMIT: begin
        if (emit_go) begin
          state_d = ret_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and list updates
  always_comb begin
    ret_d        = ret_q;
    kind_d       = kind_q;
    now_sec_d    = now_sec_q;
    now_usec_d   = now_usec_q;
    h_d          = h_q;
    psec_d       = psec_q;
    pusec_d      = pusec_q;
    rep_in_d     = rep_in_q;
    ud_in_d      = ud_in_q;
    tgt_d        = tgt_q;
    idx_d        = idx_q;
    rd_idx_d     = rd_idx_q;
    rd_vld_d     = rd_vld_q;
    issue_d      = issue_q;
    best_d       = best_q;
    best_pos_d   = best_pos_q;
    found_d      = found_q;
    pcnt_d       = pcnt_q;
    phase_d      = phase_q;
    fired_d      = fired_q;
    rec_d        = rec_q;
    arm_sec_d    = arm_sec_q;
    arm_us_d     = arm_us_q;
    in_use_d     = in_use_q;
    in_rep_d     = in_rep_q;
    pos_d        = pos_q;
    pend_st_d    = pend_st_q;
    pend_h_d     = pend_h_q;
    pend_fired_d = pend_fired_q;
    pend_data_d  = pend_data_q;
    pend_sum_d   = pend_sum_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_st_d     = rsp_st_q;
    rsp_h_d      = rsp_h_q;
    rsp_fired_d  = rsp_fired_q;
    rsp_last_d   = rsp_last_q;
    rsp_psec_d   = rsp_psec_q;
    rsp_pusec_d  = rsp_pusec_q;
    rsp_rep_d    = rsp_rep_q;
    rsp_ud_d     = rsp_ud_q;
    rsp_fc_d     = rsp_fc_q;
    ram_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d     = req_kind;
          now_sec_d  = req_i.now_sec;
          now_usec_d = req_i.now_usec;
          h_d        = req_i.handle;
          psec_d     = req_i.period_sec;
          pusec_d    = req_i.period_usec;
          rep_in_d   = req_i.repeat_count;
          ud_in_d    = req_i.user_data;
          tgt_d      = req_hidx;
          idx_d      = '0;
          issue_d    = 1'b1;
          rd_vld_d   = 1'b0;
          found_d    = 1'b0;
          phase_d    = 1'b0;
          fired_d    = '0;
          ret_d        = S_IDLE;
          pend_st_d    = ST_OK;
          pend_h_d     = '0;
          pend_fired_d = 1'b0;
          pend_data_d  = 1'b0;
          pend_sum_d   = 1'b0;
          if ((req_kind == KIND_RESTART || req_kind == KIND_CANCEL ||
               req_kind == KIND_QUERY || req_kind == KIND_SET) && !req_active) begin
            pend_st_d = ST_NOT_ACTIVE;
            pend_h_d  = req_i.handle;
          end else if ((req_kind == KIND_CREATE || req_kind == KIND_RESET) && req_zero &&
                       !(req_kind == KIND_RESET && req_active)) begin
            pend_st_d = ST_ZERO_PERIOD;
          end
        end
      end
      S_FREE: begin
        if (!in_use_q[idx_q]) begin
          tgt_d            = idx_q;
          in_use_d[idx_q]  = 1'b1;
        end else if (last_idx) begin
          pend_st_d = ST_FULL;
          ret_d     = S_IDLE;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end
      S_CAP: begin
        rec_d = ram_rdata;
        unique case (kind_q)
          KIND_CHECK: begin
            if (phase_q && expired) begin
              pend_st_d    = ST_OK;
              pend_h_d     = tgt_h;
              pend_fired_d = 1'b1;
              pend_data_d  = 1'b1;
              ret_d        = S_UNLINK;
            end
          end
          KIND_QUERY: begin
            pend_h_d    = tgt_h;
            pend_data_d = 1'b1;
            ret_d       = S_IDLE;
          end
          KIND_SET: rec_d.ud = ud_in_q;
          default: begin
          end
        endcase
      end
      S_UNLINK: begin
        for (int a = 0; a < TIMER_SLOTS; a++) begin
          if ((SW'(a) != tgt_q) && in_use_q[a] && (in_rep_q[a] == in_rep_q[tgt_q]) &&
              (pos_q[a] > pos_q[tgt_q])) begin
            pos_d[a] = pos_q[a] - SW'(1);
          end
        end
        unique case (kind_q)
          KIND_RESET: begin
            if (zero_per) begin
              in_use_d[tgt_q] = 1'b0;
              pend_st_d       = ST_ZERO_PERIOD;
              pend_h_d        = h_q;
              ret_d           = S_IDLE;
            end
          end
          KIND_CANCEL: begin
            in_use_d[tgt_q] = 1'b0;
            pend_h_d        = tgt_h;
            pend_data_d     = 1'b1;
            ret_d           = S_IDLE;
          end
          KIND_CHECK: begin
            if (phase_q || (rec_q.rep == '0)) begin
              in_use_d[tgt_q] = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      S_LOADIN: begin
        rec_d.psec  = psec_q;
        rec_d.pusec = pusec_q;
        rec_d.rep   = rep_in_q;
        rec_d.ud    = ud_in_q;
      end
      S_ARM_ADD: begin
        arm_sec_d = tu_res.sec;
        arm_us_d  = tu_res.us;
      end
      S_ARM_NORM: begin
        if (tu_res.step) begin
          arm_sec_d = tu_res.sec;
          arm_us_d  = tu_res.us;
        end else begin
          rec_d.dsec  = arm_sec_q[DSEC_W] ? '1 : arm_sec_q[DSEC_W-1:0];
          rec_d.dusec = arm_us_q[USEC_W-1:0];
          if (kind_q == KIND_CHECK) begin
            if (rec_q.rep > 0) begin
              rec_d.rep = rec_q.rep - 16'sd1;
            end
            pend_st_d    = ST_OK;
            pend_h_d     = tgt_h;
            pend_fired_d = 1'b1;
            pend_data_d  = 1'b1;
            ret_d        = S_UNLINK;
          end
        end
      end
      S_LINK: begin
        in_rep_d[tgt_q] = (rec_q.rep != '0);
        idx_d           = '0;
        issue_d         = 1'b1;
        rd_vld_d        = 1'b0;
        pcnt_d          = '0;
      end
      S_LCNT, S_CHK: begin
        if (issue_q) begin
          rd_idx_d = idx_q;
          rd_vld_d = 1'b1;
          if (last_idx) begin
            issue_d = 1'b0;
          end else begin
            idx_d = idx_q + SW'(1);
          end
        end else begin
          rd_vld_d = 1'b0;
        end
        if (state_q == S_LCNT) begin
          if (cnt_hit) begin
            pcnt_d = pcnt_q + SW'(1);
          end
        end else begin
          if (chk_hit) begin
            found_d    = 1'b1;
            best_d     = rd_idx_q;
            best_pos_d = pos_q[rd_idx_q];
          end
          if (rd_last) begin
            if (found_q || chk_hit) begin
              tgt_d = chk_hit ? rd_idx_q : best_q;
            end else begin
              phase_d = 1'b1;
              idx_d   = '0;
            end
          end
        end
      end
      S_LSHIFT: begin
        if (!in_rep_q[tgt_q]) begin
          for (int a = 0; a < TIMER_SLOTS; a++) begin
            if ((SW'(a) != tgt_q) && in_use_q[a] && !in_rep_q[a] && (pos_q[a] >= pcnt_q)) begin
              pos_d[a] = pos_q[a] + SW'(1);
            end
          end
        end
        pos_d[tgt_q] = pcnt_q;
      end
      S_WRITE: begin
        ram_we = 1'b1;
        if (kind_q == KIND_CHECK) begin
          phase_d = 1'b1;
          idx_d   = '0;
        end else begin
          pend_st_d   = ST_OK;
          pend_h_d    = tgt_h;
          pend_data_d = 1'b1;
          ret_d       = S_IDLE;
        end
      end
      S_OFIND: begin
        if (ofind_hit) begin
          tgt_d = idx_q;
        end else if (!last_idx) begin
          idx_d = idx_q + SW'(1);
        end
      end
      S_SUMMARY: begin
        pend_st_d    = ST_OK;
        pend_h_d     = '0;
        pend_fired_d = 1'b0;
        pend_data_d  = 1'b0;
        pend_sum_d   = 1'b1;
        ret_d        = S_IDLE;
      end
      S_EMIT: begin
        if (emit_go) begin
          rsp_valid_d = 1'b1;
          rsp_st_d    = pend_st_q;
          rsp_h_d     = pend_h_q;
          rsp_fired_d = pend_fired_q;
          rsp_last_d  = !pend_fired_q;
          rsp_psec_d  = pend_data_q ? rec_q.psec : '0;
          rsp_pusec_d = pend_data_q ? rec_q.pusec : '0;
          rsp_rep_d   = pend_data_q ? rec_q.rep : '0;
          rsp_ud_d    = pend_data_q ? rec_q.ud : '0;
          rsp_fc_d    = pend_sum_q ? fired_q : '0;
          if (pend_fired_q) begin
            fired_d = fired_q + FC_W'(1);
          end
          pend_fired_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      in_use_q    <= '0;
      rsp_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      issue_q     <= 1'b0;
      found_q     <= 1'b0;
      phase_q     <= 1'b0;
      fired_q     <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      in_use_q    <= in_use_d;
      rsp_valid_q <= rsp_valid_d;
      rd_vld_q    <= rd_vld_d;
      issue_q     <= issue_d;
      found_q     <= found_d;
      phase_q     <= phase_d;
      fired_q     <= fired_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    now_sec_q    <= now_sec_d;
    now_usec_q   <= now_usec_d;
    h_q          <= h_d;
    psec_q       <= psec_d;
    pusec_q      <= pusec_d;
    rep_in_q     <= rep_in_d;
    ud_in_q      <= ud_in_d;
    tgt_q        <= tgt_d;
    idx_q        <= idx_d;
    rd_idx_q     <= rd_idx_d;
    best_q       <= best_d;
    best_pos_q   <= best_pos_d;
    pcnt_q       <= pcnt_d;
    rec_q        <= rec_d;
    arm_sec_q    <= arm_sec_d;
    arm_us_q     <= arm_us_d;
    in_rep_q     <= in_rep_d;
    pos_q        <= pos_d;
    pend_st_q    <= pend_st_d;
    pend_h_q     <= pend_h_d;
    pend_fired_q <= pend_fired_d;
    pend_data_q  <= pend_data_d;
    pend_sum_q   <= pend_sum_d;
    rsp_st_q     <= rsp_st_d;
    rsp_h_q      <= rsp_h_d;
    rsp_fired_q  <= rsp_fired_d;
    rsp_last_q   <= rsp_last_d;
    rsp_psec_q   <= rsp_psec_d;
    rsp_pusec_q  <= rsp_pusec_d;
    rsp_rep_q    <= rsp_rep_d;
    rsp_ud_q     <= rsp_ud_d;
    rsp_fc_q     <= rsp_fc_d;
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_st_q;
  assign rsp_o.handle_out      = rsp_h_q;
  assign rsp_o.fired           = rsp_fired_q;
  assign rsp_o.out_period_sec  = rsp_psec_q;
  assign rsp_o.out_period_usec = rsp_pusec_q;
  assign rsp_o.out_repeat      = rsp_rep_q;
  assign rsp_o.out_user_data   = rsp_ud_q;
  assign rsp_o.fired_count     = rsp_fc_q;
  assign rsp_o.last            = rsp_last_q;

endmodule

### rtl/core/tst_ram.sv
// ----------------------------------------------------------------------------
// tst_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/tst_time_unit.sv
// ----------------------------------------------------------------------------
// tst_time_unit
// shared time arithmetic: add, one normalize step, deadline compare
// ----------------------------------------------------------------------------
module tst_time_unit (
  input  tst_pkg::tu_op_e           op_i,
  input  logic [tst_pkg::DSEC_W:0]  a_sec_i,
  input  logic [tst_pkg::USEC_W:0]  a_us_i,
  input  logic [tst_pkg::DSEC_W:0]  b_sec_i,
  input  logic [tst_pkg::USEC_W:0]  b_us_i,
  output tst_pkg::tu_res_t          res_o
);
  import tst_pkg::*;

  logic [DSEC_W+USEC_W-1:0] key_a;
  logic [DSEC_W+USEC_W-1:0] key_b;

  assign key_a = {a_sec_i[DSEC_W-1:0], a_us_i[USEC_W-1:0]};
  assign key_b = {b_sec_i[DSEC_W-1:0], b_us_i[USEC_W-1:0]};

  always_comb begin
    res_o.sec  = a_sec_i;
    res_o.us   = a_us_i;
    res_o.step = 1'b0;
    res_o.lt   = key_a < key_b;
    res_o.eq   = key_a == key_b;
    unique case (op_i)
      TU_ADD: begin
        res_o.sec = a_sec_i + b_sec_i;
        res_o.us  = a_us_i + b_us_i;
      end
      TU_NORM: begin
        if (a_us_i >= USEC_PER_SEC) begin
          res_o.sec  = a_sec_i + 33'd1;
          res_o.us   = a_us_i - USEC_PER_SEC;
          res_o.step = 1'b1;
        end
      end
      TU_CMP: begin
      end
      default: begin
      end
    endcase
  end

endmodule

### tb/tst_checker.sv
// ----------------------------------------------------------------------------
// tst_checker
// watches both channels of the software timer table, keeps its own copy of
// the slot table and the two timer lists, predicts the results of every
// accepted request and compares each result transaction field by field
// ----------------------------------------------------------------------------
module tst_checker
  import tst_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  tst_req_if    req_i,
  tst_rsp_if    rsp_i,
  output int    errors_o,
  output int    pending_o
);

  localparam int SLOTS = 16;
  localparam logic [32:0] SEC_MAX = 33'hFFFF_FFFF;

  typedef struct {
    status_e            status;
    logic [3:0]         handle;
    logic               fired;
    logic [30:0]        psec;
    logic [19:0]        pusec;
    logic signed [15:0] rep;
    logic signed [31:0] ud;
    logic [1:0]         fcount;
    logic               last;
  } timer_rsp_t;

  logic               busy     [SLOTS];
  logic               periodic [SLOTS];
  logic [31:0]        dl_sec   [SLOTS];
  logic [19:0]        dl_usec  [SLOTS];
  logic [30:0]        per_sec  [SLOTS];
  logic [19:0]        per_usec [SLOTS];
  logic signed [15:0] reps     [SLOTS];
  logic signed [31:0] word     [SLOTS];
  int                 order    [SLOTS];

  timer_rsp_t timer_rsp_q[$];
  int errors;

  assign errors_o  = errors;
  assign pending_o = timer_rsp_q.size();

  function automatic timer_rsp_t make_rsp(status_e st, logic [3:0] h, logic f,
                                          logic [30:0] ps, logic [19:0] pu,
                                          logic signed [15:0] r, logic signed [31:0] u,
                                          logic [1:0] fc, logic l);
    timer_rsp_t t;
    t.status = st; t.handle = h; t.fired = f; t.psec = ps; t.pusec = pu;
    t.rep = r; t.ud = u; t.fcount = fc; t.last = l;
    return t;
  endfunction

  function automatic timer_rsp_t slot_rsp(int s, logic f);
    return make_rsp(ST_OK, s[3:0], f, per_sec[s], per_usec[s], reps[s], word[s], 2'd0, !f);
  endfunction

  function automatic timer_rsp_t err_rsp(status_e st, logic [3:0] h);
    return make_rsp(st, h, 1'b0, '0, '0, '0, '0, 2'd0, 1'b1);
  endfunction

  task automatic arm_deadline(int s, logic [30:0] ns, logic [19:0] nu);
    logic [32:0] sec;
    logic [20:0] us;
    sec = {2'b0, ns} + {2'b0, per_sec[s]};
    us  = {1'b0, nu} + {1'b0, per_usec[s]};
    while (us >= USEC_PER_SEC) begin
      us  = us - USEC_PER_SEC;
      sec = sec + 1;
    end
    if (sec > SEC_MAX) sec = SEC_MAX;
    dl_sec[s]  = sec[31:0];
    dl_usec[s] = us[19:0];
  endtask

  function automatic bit due(int s, logic [30:0] ns, logic [19:0] nu);
    return dl_sec[s] < {1'b0, ns} || (dl_sec[s] == {1'b0, ns} && dl_usec[s] <= nu);
  endfunction

  function automatic bit sooner(int a, int b);
    return dl_sec[a] < dl_sec[b] || (dl_sec[a] == dl_sec[b] && dl_usec[a] < dl_usec[b]);
  endfunction

  function automatic bit peer(int a, int s);
    return a != s && busy[a] && periodic[a] == periodic[s];
  endfunction

  task automatic unlink(int s);
    for (int a = 0; a < SLOTS; a++)
      if (peer(a, s) && order[a] > order[s]) order[a]--;
  endtask

  task automatic link(int s);
    int p;
    p = 0;
    periodic[s] = reps[s] != 0;
    for (int a = 0; a < SLOTS; a++)
      if (peer(a, s) && (periodic[s] || sooner(a, s))) p++;
    if (!periodic[s])
      for (int a = 0; a < SLOTS; a++)
        if (peer(a, s) && order[a] >= p) order[a]++;
    order[s] = p;
  endtask

  task automatic load(int s);
    per_sec[s]  = req_i.period_sec;
    per_usec[s] = req_i.period_usec;
    reps[s]     = req_i.repeat_count;
    word[s]     = req_i.user_data;
    arm_deadline(s, req_i.now_sec, req_i.now_usec);
    link(s);
  endtask

  task automatic predict_request();
    kind_e       k;
    logic [3:0]  h;
    logic [30:0] ns;
    logic [19:0] nu;
    bit          zero_per;
    int          s, best, nf;
    k  = kind_e'(req_i.kind);
    h  = req_i.handle;
    ns = req_i.now_sec;
    nu = req_i.now_usec;
    zero_per = req_i.period_sec == 0 && req_i.period_usec == 0;
    if (k inside {KIND_RESTART, KIND_CANCEL, KIND_QUERY, KIND_SET} && !busy[h]) begin
      timer_rsp_q.push_back(err_rsp(ST_NOT_ACTIVE, h));
      return;
    end
    case (k)
      KIND_CREATE, KIND_RESET: begin
        if (k == KIND_RESET && busy[h]) begin
          unlink(h);
          if (zero_per) begin
            busy[h] = 1'b0;
            timer_rsp_q.push_back(err_rsp(ST_ZERO_PERIOD, h));
          end else begin
            load(h);
            timer_rsp_q.push_back(slot_rsp(h, 1'b0));
          end
        end else if (zero_per) begin
          timer_rsp_q.push_back(err_rsp(ST_ZERO_PERIOD, 4'd0));
        end else begin
          s = 0;
          while (s < SLOTS && busy[s]) s++;
          if (s >= SLOTS) begin
            timer_rsp_q.push_back(err_rsp(ST_FULL, 4'd0));
          end else begin
            busy[s] = 1'b1;
            load(s);
            timer_rsp_q.push_back(slot_rsp(s, 1'b0));
          end
        end
      end
      KIND_RESTART: begin
        unlink(h);
        arm_deadline(h, ns, nu);
        link(h);
        timer_rsp_q.push_back(slot_rsp(h, 1'b0));
      end
      KIND_CANCEL: begin
        unlink(h);
        busy[h] = 1'b0;
        timer_rsp_q.push_back(slot_rsp(h, 1'b0));
      end
      KIND_CHECK: begin
        nf = 0;
        best = SLOTS;
        for (int a = 0; a < SLOTS; a++)
          if (busy[a] && periodic[a] && due(a, ns, nu) &&
              (best == SLOTS || order[a] < order[best]))
            best = a;
        if (best < SLOTS) begin
          arm_deadline(best, ns, nu);
          if (reps[best] > 0) reps[best]--;
          timer_rsp_q.push_back(slot_rsp(best, 1'b1));
          nf++;
          unlink(best);
          if (reps[best] == 0) busy[best] = 1'b0;
          else link(best);
        end
        s = 0;
        while (s < SLOTS && !(busy[s] && !periodic[s] && order[s] == 0)) s++;
        if (s < SLOTS && due(s, ns, nu)) begin
          timer_rsp_q.push_back(slot_rsp(s, 1'b1));
          nf++;
          unlink(s);
          busy[s] = 1'b0;
        end
        timer_rsp_q.push_back(make_rsp(ST_OK, '0, 1'b0, '0, '0, '0, '0, nf[1:0], 1'b1));
      end
      KIND_QUERY: timer_rsp_q.push_back(slot_rsp(h, 1'b0));
      KIND_SET: begin
        word[h] = req_i.user_data;
        timer_rsp_q.push_back(slot_rsp(h, 1'b0));
      end
      default: timer_rsp_q.push_back(err_rsp(ST_OK, 4'd0));
    endcase
  endtask

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic compare_result();
    timer_rsp_t e;
    if (timer_rsp_q.size() == 0) begin
      report("result transaction with nothing expected");
      return;
    end
    e = timer_rsp_q.pop_front();
    if (rsp_i.status !== e.status)
      report($sformatf("status %0d, expected %0d", rsp_i.status, e.status));
    if (rsp_i.handle_out !== e.handle)
      report($sformatf("handle_out %0d, expected %0d", rsp_i.handle_out, e.handle));
    if (rsp_i.fired !== e.fired)
      report($sformatf("fired %0b, expected %0b", rsp_i.fired, e.fired));
    if (rsp_i.out_period_sec !== e.psec)
      report($sformatf("out_period_sec %0d, expected %0d", rsp_i.out_period_sec, e.psec));
    if (rsp_i.out_period_usec !== e.pusec)
      report($sformatf("out_period_usec %0d, expected %0d", rsp_i.out_period_usec, e.pusec));
    if (rsp_i.out_repeat !== e.rep)
      report($sformatf("out_repeat %0d, expected %0d", rsp_i.out_repeat, e.rep));
    if (rsp_i.out_user_data !== e.ud)
      report($sformatf("out_user_data %0d, expected %0d", rsp_i.out_user_data, e.ud));
    if (rsp_i.fired_count !== e.fcount)
      report($sformatf("fired_count %0d, expected %0d", rsp_i.fired_count, e.fcount));
    if (rsp_i.last !== e.last)
      report($sformatf("last %0b, expected %0b", rsp_i.last, e.last));
  endtask

  initial begin
    errors = 0;
    for (int a = 0; a < SLOTS; a++) begin
      busy[a] = 1'b0; periodic[a] = 1'b0; dl_sec[a] = '0; dl_usec[a] = '0;
      per_sec[a] = '0; per_usec[a] = '0; reps[a] = '0; word[a] = '0; order[a] = 0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) compare_result();
      if (req_i.valid && req_i.ready) predict_request();
    end
  end

endmodule

### tb/tb_software_timer_table.sv
// ----------------------------------------------------------------------------
// tb_software_timer_table
// drives timer requests into the table: a directed opening over the error
// cases, full table and extreme fields, then random request mixes with a
// moving clock of seconds and microseconds, in four idle and stall phases
// ----------------------------------------------------------------------------
module tb_software_timer_table;
  import tst_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 250;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   errors;
  int   pending;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;
  logic [30:0] cur_sec;
  logic [19:0] cur_usec;

  tst_req_if req_if ();
  tst_rsp_if rsp_if ();

  software_timer_table uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  tst_checker checker_i (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rsp_if.ready <= $urandom_range(99) >= stall_pct;
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(kind_e k, logic [3:0] h, logic [30:0] ps, logic [19:0] pu,
                      logic signed [15:0] r, logic signed [31:0] u);
    if ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.kind         <= k;
    req_if.now_sec      <= cur_sec;
    req_if.now_usec     <= cur_usec;
    req_if.handle       <= h;
    req_if.period_sec   <= ps;
    req_if.period_usec  <= pu;
    req_if.repeat_count <= r;
    req_if.user_data    <= u;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic advance_time();
    logic [20:0] us;
    if ($urandom_range(19) == 0) begin
      cur_sec = cur_sec + $urandom_range(5);
    end
    us = {1'b0, cur_usec} + $urandom_range(600000);
    if (us >= USEC_PER_SEC) begin
      us = us - USEC_PER_SEC;
      cur_sec = cur_sec + 1;
    end
    cur_usec = us[19:0];
  endtask

  task automatic send_random();
    int          sel;
    kind_e       k;
    logic [30:0] ps;
    logic [19:0] pu;
    logic signed [15:0] r;
    sel = $urandom_range(99);
    if (sel < 22) k = KIND_CREATE;
    else if (sel < 32) k = KIND_RESET;
    else if (sel < 40) k = KIND_RESTART;
    else if (sel < 50) k = KIND_CANCEL;
    else if (sel < 80) k = KIND_CHECK;
    else if (sel < 88) k = KIND_QUERY;
    else if (sel < 97) k = KIND_SET;
    else k = KIND_NONE;
    sel = $urandom_range(99);
    if (sel < 5) begin
      ps = '0; pu = '0;
    end else if (sel < 85) begin
      ps = $urandom_range(2);
      pu = $urandom_range(20'hFFFFF);
    end else begin
      ps = $urandom;
      pu = $urandom;
    end
    sel = $urandom_range(99);
    if (sel < 40) r = 0;
    else if (sel < 70) r = $urandom_range(1, 3);
    else if (sel < 85) r = -1;
    else r = $urandom;
    advance_time();
    send(k, $urandom_range(15), ps, pu, r, $urandom);
  endtask

  initial begin
    rst_ni = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    req_if.valid = 1'b0;
    req_if.kind = KIND_NONE;
    req_if.now_sec = '0;
    req_if.now_usec = '0;
    req_if.handle = '0;
    req_if.period_sec = '0;
    req_if.period_usec = '0;
    req_if.repeat_count = '0;
    req_if.user_data = '0;
    cur_sec = '0;
    cur_usec = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(KIND_CREATE, 4'd0, '0, '0, 16'sd1, 32'sd5);
    send(KIND_CREATE, 4'd0, '1, 20'd999999, 16'sd0, 32'h7FFF_FFFF);
    send(KIND_CREATE, 4'd0, 31'd0, 20'hFFFFF, -16'sd32768, 32'h8000_0000);
    send(KIND_CREATE, 4'd0, 31'd0, 20'd1, 16'sd32767, 32'sd0);
    send(KIND_QUERY, 4'd0, '0, '0, '0, '0);
    send(KIND_SET, 4'd1, '0, '0, '0, 32'hDEAD_BEEF);
    send(KIND_RESTART, 4'd1, '0, '0, '0, '0);
    send(KIND_QUERY, 4'd15, '0, '0, '0, '0);
    send(KIND_CANCEL, 4'd15, '0, '0, '0, '0);
    send(KIND_RESTART, 4'd14, '0, '0, '0, '0);
    send(KIND_SET, 4'd13, '0, '0, '0, '0);
    send(KIND_RESET, 4'd0, '0, '0, '0, '0);
    send(KIND_RESET, 4'd14, 31'd0, 20'd500000, 16'sd2, 32'sd7);
    send(KIND_RESET, 4'd1, 31'd0, 20'd3, 16'sd0, 32'sd9);
    send(KIND_NONE, 4'd9, '1, '1, '1, '1);
    for (int i = 0; i < 13; i++) send(KIND_CREATE, 4'd0, 31'd0, 20'd2, 16'sd0, $urandom);
    cur_sec = '1;
    cur_usec = 20'd999999;
    send(KIND_CHECK, 4'd0, '0, '0, '0, '0);
    send(KIND_CHECK, 4'd0, '0, '0, '0, '0);
    send(KIND_CANCEL, 4'd2, '0, '0, '0, '0);
    cur_sec = '0;
    cur_usec = '0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) send_random();
    end
    req_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/tst_pkg.sv
rtl/core/tst_if.sv
rtl/core/tst_ram.sv
rtl/core/tst_time_unit.sv
rtl/core/software_timer_table.sv
tb/tst_checker.sv
tb/tb_software_timer_table.sv
